FILE: design/fsp_pkg.sv
// Shared constants, types and arithmetic helpers for the Fibonacci sphere point generator.
package fsp_pkg;

	// Lattice limits and fixed-point format
	localparam int unsigned MAX_POINTS = 1024;
	localparam int unsigned FRAC_BITS  = 14;
	localparam logic [15:0] ONE        = 16'd16384;
	localparam logic [28:0] ONE_SQ     = 29'd268435456;

	// Golden angle as a phase of one turn = 65536, and pi/2 in Q30
	localparam logic [14:0] GOLDEN_PHASE = 15'd25033;
	localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
	localparam logic [30:0] Q30_ONE      = 31'd1073741824;

	// Taylor terms x^2 .. x^10 and their factorial divisors
	localparam int NUM_TERMS   = 9;
	localparam int RECIP_SHIFT = 36;
	localparam logic [21:0] TERM_DIV [NUM_TERMS] = '{
		22'd2, 22'd6, 22'd24, 22'd120, 22'd720, 22'd5040, 22'd40320, 22'd362880, 22'd3628800
	};
	localparam logic [20:0] TERM_HALF [NUM_TERMS] = '{
		21'(2 / 2), 21'(6 / 2), 21'(24 / 2), 21'(120 / 2), 21'(720 / 2), 21'(5040 / 2),
		21'(40320 / 2), 21'(362880 / 2), 21'(3628800 / 2)
	};
	localparam logic [36:0] TERM_RECIP [NUM_TERMS] = '{
		37'((64'd1 << 36) / 64'd2),      37'((64'd1 << 36) / 64'd6),
		37'((64'd1 << 36) / 64'd24),     37'((64'd1 << 36) / 64'd120),
		37'((64'd1 << 36) / 64'd720),    37'((64'd1 << 36) / 64'd5040),
		37'((64'd1 << 36) / 64'd40320),  37'((64'd1 << 36) / 64'd362880),
		37'((64'd1 << 36) / 64'd3628800)
	};

	// Cosine and sine of the azimuth as magnitude and sign, magnitudes in Q30
	typedef struct packed {
		logic [30:0] cos_mag;
		logic        cos_neg;
		logic [30:0] sin_mag;
		logic        sin_neg;
	} trig_t;

	// Q30 product rounded to nearest, wrapping at 64 bits
	function automatic logic [33:0] mul_q30(input logic [33:0] a, input logic [33:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + (64'd1 << 29);
		return p[63:30];
	endfunction

endpackage

FILE: design/fsp_div.sv
// Pipelined restoring divider: rounded height quotient, four bits per stage.
module fsp_div (
	input  logic        clk,
	input  logic        en,
	input  logic [25:0] num,
	input  logic [9:0]  den,
	output logic [15:0] quo
);

	localparam int STAGES = 4;
	localparam int STEPS  = 4;

	logic [9:0]  rem_s [STAGES];
	logic [15:0] quo_s [STAGES];
	logic [15:0] low_s [STAGES];
	logic [9:0]  rem_nx [STAGES];
	logic [15:0] quo_nx [STAGES];
	logic [15:0] low_nx [STAGES];

	// Shift-subtract steps for every stage
	always_comb begin
		logic [9:0]  r;
		logic [15:0] q;
		logic [15:0] l;
		logic [10:0] t;
		for (int k = 0; k < STAGES; k++) begin
			if (k == 0) begin
				r = num[25:16];
				q = '0;
				l = num[15:0];
			end else begin
				r = rem_s[k-1];
				q = quo_s[k-1];
				l = low_s[k-1];
			end
			for (int j = 0; j < STEPS; j++) begin
				t = {r, l[15]};
				l = {l[14:0], 1'b0};
				if (t >= {1'b0, den}) begin
					r = 10'(t - {1'b0, den});
					q = {q[14:0], 1'b1};
				end else begin
					r = t[9:0];
					q = {q[14:0], 1'b0};
				end
			end
			rem_nx[k] = r;
			quo_nx[k] = q;
			low_nx[k] = l;
		end
	end

	// Stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STAGES; k++) begin
				rem_s[k] <= rem_nx[k];
				quo_s[k] <= quo_nx[k];
				low_s[k] <= low_nx[k];
			end
		end
	end

	assign quo = quo_s[STAGES-1];

endmodule

FILE: design/fsp_sqrt.sv
// Pipelined digit-by-digit square root of the ring radius, three digits per stage.
module fsp_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [28:0] rad,
	output logic [14:0] root
);

	localparam int STAGES = 5;
	localparam int STEPS  = 3;

	logic [28:0] rem_s [STAGES];
	logic [28:0] res_s [STAGES];
	logic [28:0] rem_nx [STAGES];
	logic [28:0] res_nx [STAGES];

	// Trial subtraction, one result bit per step
	always_comb begin
		logic [28:0] r;
		logic [28:0] s;
		logic [28:0] b;
		logic [29:0] trial;
		for (int k = 0; k < STAGES; k++) begin
			if (k == 0) begin
				r = rad;
				s = '0;
			end else begin
				r = rem_s[k-1];
				s = res_s[k-1];
			end
			for (int j = 0; j < STEPS; j++) begin
				b = 29'(1) << (28 - 2 * (k * STEPS + j));
				trial = {1'b0, s} + {1'b0, b};
				if ({1'b0, r} >= trial) begin
					r = 29'({1'b0, r} - trial);
					s = (s >> 1) + b;
				end else begin
					s = s >> 1;
				end
			end
			rem_nx[k] = r;
			res_nx[k] = s;
		end
	end

	// Stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STAGES; k++) begin
				rem_s[k] <= rem_nx[k];
				res_s[k] <= res_nx[k];
			end
		end
	end

	// Round to nearest
	assign root = 15'(res_s[STAGES-1] + 29'(rem_s[STAGES-1] > res_s[STAGES-1]));

endmodule

FILE: design/fsp_sincos.sv
// Pipelined quarter-wave Taylor sine and cosine of the golden-angle azimuth.
module fsp_sincos (
	input  logic           clk,
	input  logic           en,
	input  logic [9:0]     idx,
	output fsp_pkg::trig_t trig
);

	localparam int NT = fsp_pkg::NUM_TERMS;

	logic [15:0] phase_s1;
	logic [1:0]  quad_s [2:8];
	logic [33:0] x_s    [2:8];
	logic [33:0] x2_s3, x2_s4, x2_s5;
	logic [33:0] x3_s4, x3_s5;
	logic [33:0] x4_s4, x4_s5;
	logic [33:0] x5_s5, x6_s5, x8_s5;
	logic [34:0] tn_s6  [NT];
	logic [34:0] tn_s7  [NT];
	logic [33:0] est_s7 [NT];
	logic [33:0] q_s8   [NT];
	logic [33:0] est_c  [NT];
	logic [33:0] q_c    [NT];
	fsp_pkg::trig_t trig_s9;
	fsp_pkg::trig_t trig_c;

	function automatic logic [30:0] clamp_q30(input logic signed [37:0] v);
		if (v < 0)
			return '0;
		else if (v > $signed({7'd0, fsp_pkg::Q30_ONE}))
			return fsp_pkg::Q30_ONE;
		else
			return v[30:0];
	endfunction

	// Reciprocal estimate of each factorial division
	always_comb begin
		logic [71:0] prod;
		for (int k = 0; k < NT; k++) begin
			prod = 72'(tn_s6[k]) * 72'(fsp_pkg::TERM_RECIP[k]);
			est_c[k] = prod[69:36];
		end
	end

	// Correct the estimate by one where the remainder still holds a divisor
	always_comb begin
		logic [34:0] back;
		logic [34:0] rem;
		for (int k = 0; k < NT; k++) begin
			back = 35'(35'(est_s7[k]) * 35'(fsp_pkg::TERM_DIV[k]));
			rem  = tn_s7[k] - back;
			q_c[k] = est_s7[k] + 34'(rem >= 35'(fsp_pkg::TERM_DIV[k]));
		end
	end

	// Series sums, clamp and quadrant fold
	always_comb begin
		logic signed [37:0] sv;
		logic signed [37:0] cv;
		logic [30:0] s;
		logic [30:0] c;
		sv = $signed({4'd0, x_s[8]}) - $signed({4'd0, q_s8[1]}) + $signed({4'd0, q_s8[3]})
		   - $signed({4'd0, q_s8[5]}) + $signed({4'd0, q_s8[7]});
		cv = $signed({7'd0, fsp_pkg::Q30_ONE}) - $signed({4'd0, q_s8[0]})
		   + $signed({4'd0, q_s8[2]}) - $signed({4'd0, q_s8[4]})
		   + $signed({4'd0, q_s8[6]}) - $signed({4'd0, q_s8[8]});
		s = clamp_q30(sv);
		c = clamp_q30(cv);
		case (quad_s[8])
			2'd0: trig_c = '{cos_mag: c, cos_neg: 1'b0, sin_mag: s, sin_neg: 1'b0};
			2'd1: trig_c = '{cos_mag: s, cos_neg: 1'b1, sin_mag: c, sin_neg: 1'b0};
			2'd2: trig_c = '{cos_mag: c, cos_neg: 1'b1, sin_mag: s, sin_neg: 1'b1};
			default: trig_c = '{cos_mag: s, cos_neg: 1'b0, sin_mag: c, sin_neg: 1'b1};
		endcase
	end

	// Stage registers: phase, angle, powers, terms, quotients, result
	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= 16'(26'(idx) * 26'(fsp_pkg::GOLDEN_PHASE));

			quad_s[2] <= phase_s1[15:14];
			x_s[2]    <= 34'((46'(phase_s1[13:0]) * 46'(fsp_pkg::HALF_PI_Q30) + 46'd8192) >> 14);
			for (int k = 3; k <= 8; k++) begin
				quad_s[k] <= quad_s[k-1];
				x_s[k]    <= x_s[k-1];
			end

			x2_s3 <= fsp_pkg::mul_q30(x_s[2], x_s[2]);

			x2_s4 <= x2_s3;
			x3_s4 <= fsp_pkg::mul_q30(x2_s3, x_s[3]);
			x4_s4 <= fsp_pkg::mul_q30(x2_s3, x2_s3);

			x2_s5 <= x2_s4;
			x3_s5 <= x3_s4;
			x4_s5 <= x4_s4;
			x5_s5 <= fsp_pkg::mul_q30(x4_s4, x_s[4]);
			x6_s5 <= fsp_pkg::mul_q30(x4_s4, x2_s4);
			x8_s5 <= fsp_pkg::mul_q30(x4_s4, x4_s4);

			// numerators with half divisor added for rounding
			tn_s6[0] <= 35'(x2_s5) + 35'(fsp_pkg::TERM_HALF[0]);
			tn_s6[1] <= 35'(x3_s5) + 35'(fsp_pkg::TERM_HALF[1]);
			tn_s6[2] <= 35'(x4_s5) + 35'(fsp_pkg::TERM_HALF[2]);
			tn_s6[3] <= 35'(x5_s5) + 35'(fsp_pkg::TERM_HALF[3]);
			tn_s6[4] <= 35'(x6_s5) + 35'(fsp_pkg::TERM_HALF[4]);
			tn_s6[5] <= 35'(fsp_pkg::mul_q30(x6_s5, x_s[5])) + 35'(fsp_pkg::TERM_HALF[5]);
			tn_s6[6] <= 35'(x8_s5) + 35'(fsp_pkg::TERM_HALF[6]);
			tn_s6[7] <= 35'(fsp_pkg::mul_q30(x8_s5, x_s[5])) + 35'(fsp_pkg::TERM_HALF[7]);
			tn_s6[8] <= 35'(fsp_pkg::mul_q30(x8_s5, x2_s5)) + 35'(fsp_pkg::TERM_HALF[8]);

			for (int k = 0; k < NT; k++) begin
				tn_s7[k]  <= tn_s6[k];
				est_s7[k] <= est_c[k];
				q_s8[k]   <= q_c[k];
			end

			trig_s9 <= trig_c;
		end
	end

	assign trig = trig_s9;

endmodule

FILE: design/fibonacci_sphere_point.sv
// Fibonacci sphere point generator: top level with height, radius and output stages.
//
// Usage: write the point count on the configuration channel (cfg_valid/cfg_ready,
// always ready) while the block is idle; counts above 1024 act as 1024. Then
// present point indices on the input channel (in_valid/in_stall). Each accepted
// index yields one result on the output channel (out_valid/out_stall): the unit
// direction dir_x, dir_y, dir_z in signed Q2.14 and point_valid, which is low
// with a zero vector when the index is not below the count.
// One index is accepted every cycle while in_stall is low. The depth is set by
// the 16-bit height divider (four stages), the 15-digit square root (five
// stages) and the Taylor sine/cosine chain (nine stages) that runs beside them.
// A stalled result holds on the output register; the pipeline then holds
// while the last stage is full, and in_stall rises, so nothing is lost or
// repeated. All stages hold together, empty ones included. Reset empties the
// pipeline and sets the point count to 1.
module fibonacci_sphere_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [10:0]        point_count,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         point_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic               point_valid
);

	localparam int LAT = 14;

	logic [10:0] count_q;
	logic [10:0] n_eff;
	logic        en;
	logic [LAT:1] vld_s;

	logic [9:0]  i_s1;
	logic [9:0]  den_s1;
	logic [25:0] num_s1;
	logic [13:1] hit_s;
	logic [5:1]  unit_s;
	logic [15:0] quo;
	logic [15:0] y_s [6:13];
	logic [14:0] ym_s6;
	logic [28:0] rad_s7;
	logic [14:0] root;
	logic [14:0] r_s13;
	fsp_pkg::trig_t trig;
	fsp_pkg::trig_t trig_s11, trig_s12, trig_s13;
	logic [15:0] yq;
	logic [45:0] xp, zp;
	logic [15:0] xv, zv;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 11'd1;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= point_count;
		end
	end

	assign n_eff = (count_q > 11'(fsp_pkg::MAX_POINTS)) ? 11'(fsp_pkg::MAX_POINTS) : count_q;

	// Pipeline advances unless a finished result waits on a stalled output
	assign en       = !(vld_s[LAT] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// Submodules
	fsp_div u_div (
		.clk (clk),
		.en  (en),
		.num (num_s1),
		.den (den_s1),
		.quo (quo)
	);

	fsp_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s7),
		.root (root)
	);

	fsp_sincos u_sincos (
		.clk  (clk),
		.en   (en),
		.idx  (i_s1),
		.trig (trig)
	);

	// Height from the rounded quotient
	assign yq = unit_s[5] ? 16'd0 : fsp_pkg::ONE - quo;

	// Output scaling of the radius by cosine and sine
	assign xp = 46'(r_s13) * 46'(trig_s13.cos_mag) + (46'd1 << 29);
	assign zp = 46'(r_s13) * 46'(trig_s13.sin_mag) + (46'd1 << 29);
	assign xv = xp[45:30];
	assign zv = zp[45:30];

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			i_s1     <= point_index;
			den_s1   <= 10'(n_eff - 11'd1);
			num_s1   <= {1'b0, point_index, 15'd0} + 26'(10'(n_eff - 11'd1) >> 1);
			hit_s[1] <= {1'b0, point_index} < n_eff;
			unit_s[1] <= n_eff == 11'd1;
			for (int k = 2; k <= 13; k++) hit_s[k] <= hit_s[k-1];
			for (int k = 2; k <= 5; k++) unit_s[k] <= unit_s[k-1];

			y_s[6] <= yq;
			ym_s6  <= yq[15] ? 15'(-yq) : yq[14:0];
			for (int k = 7; k <= 13; k++) y_s[k] <= y_s[k-1];

			rad_s7 <= fsp_pkg::ONE_SQ - 29'(30'(ym_s6) * 30'(ym_s6));

			r_s13    <= root;
			trig_s11 <= trig;
			trig_s12 <= trig_s11;
			trig_s13 <= trig_s12;

			point_valid <= hit_s[13];
			dir_y <= hit_s[13] ? y_s[13] : 16'sd0;
			dir_x <= !hit_s[13] ? 16'sd0 : (trig_s13.cos_neg ? -xv : xv);
			dir_z <= !hit_s[13] ? 16'sd0 : (trig_s13.sin_neg ? -zv : zv);
		end
	end

	assign out_valid = vld_s[LAT];

	// Checks on the results
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
		else $error("invalid point carries a non-zero vector");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> dir_y <= 16'sd16384 && dir_y >= -16'sd16384)
		else $error("height out of unit range");

	a_xz_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384
			&& dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
		else $error("horizontal component out of unit range");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_valid))
		else $error("stalled result dropped from the last stage");

endmodule
